>>> design/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants, register codes and beat types of the direct form I
// biquad filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int CHANNELS       = 4;
	localparam int COEF_FRAC_BITS = 14;

	localparam int CH_W       = 2;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int HIST_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W     = COEF_W + SAMPLE_W;
	localparam int ACC_W      = PROD_W + 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;
	localparam int COEF_ONE   = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF_COEF_0 = 3'd0,
		REG_FF_COEF_1 = 3'd1,
		REG_FF_COEF_2 = 3'd2,
		REG_FB_COEF_1 = 3'd3,
		REG_FB_COEF_2 = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]            channel;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]            channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} result_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] h1;
		logic signed [SAMPLE_W-1:0] h2;
	} hist_t;

endpackage

>>> design/iirdf1_front.sv
// ----------------------------------------------------------------------------
// iirdf1_front
// Input side: a two-entry queue that takes sample beats and hands the
// oldest one to the filter datapath.
// ----------------------------------------------------------------------------
module iirdf1_front import iirdf1_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  head_valid,
	output item_t head_item,
	input  logic  head_pop
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/iirdf1_resq.sv
// ----------------------------------------------------------------------------
// iirdf1_resq
// Result side: a two-entry queue that holds filtered beats until the
// consumer pops them.
// ----------------------------------------------------------------------------
module iirdf1_resq import iirdf1_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    wr_ready,
	output logic    empty,
	output result_t rd_data,
	input  logic    pop
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = wr_en && wr_ready;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/iirdf1_back.sv
// ----------------------------------------------------------------------------
// iirdf1_back
// Filter datapath: coefficient registers, per-channel history, a multiply
// stage and an accumulate, round and saturate stage.
// ----------------------------------------------------------------------------
module iirdf1_back import iirdf1_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	input  logic                 head_valid,
	input  item_t                head_item,
	output logic                 head_pop,
	output logic                 res_push,
	output result_t              res_data,
	input  logic                 res_ready
);

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(SAMPLE_MIN);

	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

	hist_t x_hist_q [CHANNELS];
	hist_t y_hist_q [CHANNELS];

	logic                       s1_valid_s1;
	logic [CH_W-1:0]            ch_s1;
	logic [HIST_IDX_W-1:0]      idx_s1;
	logic                       in_range_s1;
	logic signed [SAMPLE_W-1:0] y1_s1;
	logic signed [PROD_W-1:0]   pb0_s1, pb1_s1, pb2_s1, pa1_s1, pa2_s1;

	logic [HIST_IDX_W-1:0]      head_idx;
	logic                       head_in_range;
	hist_t                      xh;
	hist_t                      yh;
	logic                       s1_adv;
	logic                       hazard;
	logic                       issue;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    rounded;
	logic signed [SAMPLE_W-1:0] y_val;
	logic                       clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_W'(COEF_ONE);
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FF_COEF_0: b0_q <= cfg_data;
				REG_FF_COEF_1: b1_q <= cfg_data;
				REG_FF_COEF_2: b2_q <= cfg_data;
				REG_FB_COEF_1: a1_q <= cfg_data;
				REG_FB_COEF_2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign head_idx      = HIST_IDX_W'(head_item.channel);
	assign head_in_range = (int'(head_item.channel) < CHANNELS);
	assign xh            = x_hist_q[head_idx];
	assign yh            = y_hist_q[head_idx];

	assign s1_adv   = s1_valid_s1 && res_ready;
	assign hazard   = s1_valid_s1 && (ch_s1 == head_item.channel);
	assign issue    = head_valid && (!s1_valid_s1 || res_ready) && !hazard;
	assign head_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (issue) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1       <= head_item.channel;
			idx_s1      <= head_idx;
			in_range_s1 <= head_in_range;
			y1_s1       <= yh.h1;
			pb0_s1      <= PROD_W'(b0_q) * PROD_W'(head_item.sample);
			pb1_s1      <= PROD_W'(b1_q) * PROD_W'(xh.h1);
			pb2_s1      <= PROD_W'(b2_q) * PROD_W'(xh.h2);
			pa1_s1      <= PROD_W'(a1_q) * PROD_W'(yh.h1);
			pa2_s1      <= PROD_W'(a2_q) * PROD_W'(yh.h2);
		end
	end

	always_comb begin
		acc     = ACC_W'(pb0_s1) + ACC_W'(pb1_s1) + ACC_W'(pb2_s1)
		        - ACC_W'(pa1_s1) - ACC_W'(pa2_s1);
		rounded = (acc + RND_HALF) >>> COEF_FRAC_BITS;
		y_val   = rounded[SAMPLE_W-1:0];
		clip    = 1'b0;
		priority if (!in_range_s1) begin
			y_val = '0;
		end else if (rounded > Y_MAX) begin
			y_val = SAMPLE_W'(SAMPLE_MAX);
			clip  = 1'b1;
		end else if (rounded < Y_MIN) begin
			y_val = SAMPLE_W'(SAMPLE_MIN);
			clip  = 1'b1;
		end
	end

	assign res_push         = s1_adv;
	assign res_data.channel = ch_s1;
	assign res_data.sample  = y_val;
	assign res_data.clipped = clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else begin
			if (issue && head_in_range) begin
				x_hist_q[head_idx] <= '{h1: head_item.sample, h2: xh.h1};
			end
			if (s1_adv && in_range_s1) begin
				y_hist_q[idx_s1] <= '{h1: y_val, h2: y1_s1};
			end
		end
	end

endmodule

>>> design/iir_direct_form_one_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Multi-channel direct form I biquad, Q3.14 coefficients, 16-bit samples.
// ----------------------------------------------------------------------------
// Samples enter through a two-entry input queue, go through a multiply stage
// (five products in parallel) and an accumulate, round and saturate stage,
// and wait in a two-entry result queue. One sample per cycle is sustained
// while consecutive samples belong to different channels and the result
// queue has room; a sample of the same channel as the one before waits for
// the accumulate stage to write back the output its feedback products need.
// Coefficients are to be written only while no sample is in flight; the user
// is bound by this, the block does not enforce it.
module iir_direct_form_one_filter import iirdf1_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [CH_W-1:0]            channel,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       empty,
	input  logic                       pop,
	output logic [CH_W-1:0]            out_channel,
	output logic signed [SAMPLE_W-1:0] filtered_sample,
	output logic                       clipped,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_W-1:0]          cfg_data
);

	item_t   in_item;
	item_t   head_item;
	logic    head_valid;
	logic    head_pop;
	logic    res_push;
	logic    res_ready;
	result_t res_data;
	result_t out_data;

	assign in_item.channel = channel;
	assign in_item.sample  = sample;

	iirdf1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (in_item),
		.full       (full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop)
	);

	iirdf1_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop),
		.res_push   (res_push),
		.res_data   (res_data),
		.res_ready  (res_ready)
	);

	iirdf1_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_push),
		.wr_data  (res_data),
		.wr_ready (res_ready),
		.empty    (empty),
		.rd_data  (out_data),
		.pop      (pop)
	);

	assign out_channel     = out_data.channel;
	assign filtered_sample = out_data.sample;
	assign clipped         = out_data.clipped;

endmodule
